[design/bpa_pkg.sv]
// Shared types and constants of the bitmap page allocator.
package bpa_pkg;

    // Fixed field widths
    localparam int BASE_W     = 36;
    localparam int REGION_W   = 13;
    localparam int ADDR_W     = 48;
    localparam int ORDER_W    = 4;
    localparam int STATUS_W   = 3;
    localparam int PAGE_SHIFT = 12;
    localparam int WORD_BITS  = 64;
    localparam int CFG_IDX_W  = 1;

    localparam logic [REGION_W-1:0] REGION_RESET = 13'd4096;

    // Request codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_PAGES = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_DOUBLE  = 3'd2,
        ST_OUTSIDE = 3'd3,
        ST_UNSUP   = 3'd4
    } status_t;

    // Controller states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_RANGE = 5'b00100,
        S_SCAN  = 5'b01000,
        S_ADDR  = 5'b10000
    } state_t;

    // Bitmap memory port strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ram_ctl_t;

endpackage

[design/bpa_bitmap_ram.sv]
// Used-page bitmap memory with a clearing pass after reset.
module bpa_bitmap_ram #(
    parameter int WORDS = 64,
    parameter int AW    = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bpa_pkg::ram_ctl_t              ctl,
    input  logic [AW-1:0]                  rd_addr,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [bpa_pkg::WORD_BITS-1:0]  wr_data,
    output logic [bpa_pkg::WORD_BITS-1:0]  rd_data,
    output logic                           clr_busy
);

    logic [bpa_pkg::WORD_BITS-1:0] bitmap_mem [WORDS];
    logic [bpa_pkg::WORD_BITS-1:0] rd_data_reg;
    logic [AW-1:0]                 clr_addr_reg;
    logic [AW-1:0]                 clr_addr_next;
    logic                          clr_busy_reg;
    logic                          clr_busy_next;

    // Clearing sweep: one word per cycle
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(WORDS - 1))
                clr_busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // Single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            bitmap_mem[clr_addr_reg] <= '0;
        else if (ctl.wr_en)
            bitmap_mem[wr_addr] <= wr_data;
        if (ctl.rd_en)
            rd_data_reg <= bitmap_mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

[design/bitmap_page_allocator_top.sv]
// Top level of the bitmap page allocator: request sequencer around the bitmap memory.
//
//  channel   signals                                direction  handshake
//  request   start, busy, cmd, address, order       in         start & !busy
//  result    done, status, page_address             out        done, one cycle
//  config    cfg_wr_en, cfg_index, cfg_data         in         cfg_wr_en
//
//  Alloc: the scan reads at most ceil(min(region_pages,PAGES)/64) bitmap words, one
//  word per cycle through the memory's single read port.
//  Free: the scan reads each bitmap word the range covers.
//  After reset the bitmap is cleared one word per cycle, with busy high.
//  Results cannot be stalled; a new request is taken in the cycle done is shown.
module bitmap_page_allocator_top #(
    parameter int PAGES     = 4096,
    parameter int MAX_ORDER = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            cmd,
    input  logic [bpa_pkg::ADDR_W-1:0]      address,
    input  logic [bpa_pkg::ORDER_W-1:0]     order,
    output logic                            done,
    output logic [bpa_pkg::STATUS_W-1:0]    status,
    output logic [bpa_pkg::ADDR_W-1:0]      page_address,
    input  logic                            cfg_wr_en,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpa_pkg::BASE_W-1:0]      cfg_data
);

    localparam int WORDS  = (PAGES + 63) / 64;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PG_W   = $clog2(PAGES + 1);
    localparam int CNT_W  = (PG_W > bpa_pkg::REGION_W) ? PG_W : bpa_pkg::REGION_W;
    localparam int RW     = ((CNT_W > MAX_ORDER) ? CNT_W : MAX_ORDER) + 1;
    localparam int WN_W   = RW - 6;
    localparam int BASE_W = bpa_pkg::BASE_W;
    localparam int WB     = bpa_pkg::WORD_BITS;

    // Lowest clear bit of a word: byte select, then bit select
    function automatic logic [5:0] first_zero(input logic [WB-1:0] w);
        logic [2:0] byte_sel;
        logic [2:0] bit_sel;
        logic [7:0] b;
        byte_sel = 3'd0;
        for (int k = 7; k >= 0; k--)
            if (w[k*8 +: 8] != 8'hff)
                byte_sel = 3'(k);
        b = w[byte_sel*8 +: 8];
        bit_sel = 3'd0;
        for (int k = 7; k >= 0; k--)
            if (!b[k])
                bit_sel = 3'(k);
        return {byte_sel, bit_sel};
    endfunction

    // Control registers
    bpa_pkg::state_t              state_reg, state_next;
    logic                         done_reg, done_next;
    logic                         iss_act_reg, iss_act_next;
    logic                         ev_v_reg, ev_v_next;
    logic [BASE_W-1:0]            pool_base_reg;
    logic [bpa_pkg::REGION_W-1:0] region_reg;

    // Payload registers
    logic                         cmd_reg, cmd_next;
    logic [BASE_W-1:0]            page_reg, page_next;
    logic [bpa_pkg::ORDER_W-1:0]  order_reg, order_next;
    logic [bpa_pkg::REGION_W-1:0] offs_reg, offs_next;
    logic [RW-1:0]                lo_reg, lo_next;
    logic [RW-1:0]                hi_m1_reg, hi_m1_next;
    logic                         flag_reg, flag_next;
    logic [WN_W-1:0]              last_w_reg, last_w_next;
    logic [WN_W-1:0]              iss_w_reg, iss_w_next;
    logic [WN_W-1:0]              ev_w_reg, ev_w_next;
    logic [RW-1:0]                found_reg, found_next;
    bpa_pkg::status_t             status_reg, status_next;
    logic [bpa_pkg::ADDR_W-1:0]   page_address_reg, page_address_next;

    // Memory interface
    bpa_pkg::ram_ctl_t            ram_ctl;
    logic [WB-1:0]                ram_wdata;
    logic [WB-1:0]                ram_rdata;
    logic                         clr_busy;

    // Datapath helpers
    logic [CNT_W-1:0]             end_pg;
    logic [BASE_W:0]              diff;
    logic [RW-1:0]                count;
    logic [RW-1:0]                sum;
    logic [RW-1:0]                hi;
    logic                         over_end;
    logic [5:0]                   zbit;
    logic [RW-1:0]                cand;
    logic [5:0]                   lo_b;
    logic [5:0]                   hi_b;
    logic [WB-1:0]                mask;
    logic                         accept;

    bpa_bitmap_ram #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ram_ctl),
        .rd_addr  (iss_w_reg[AW-1:0]),
        .wr_addr  (ev_w_reg[AW-1:0]),
        .wr_data  (ram_wdata),
        .rd_data  (ram_rdata),
        .clr_busy (clr_busy)
    );

    assign busy   = clr_busy || (state_reg != bpa_pkg::S_IDLE);
    assign accept = start && !busy;

    // Usable bitmap end and range arithmetic
    assign end_pg   = (CNT_W'(region_reg) < CNT_W'(PAGES)) ? CNT_W'(region_reg) : CNT_W'(PAGES);
    assign diff     = {1'b0, page_reg} - {1'b0, pool_base_reg};
    assign count    = RW'(1) << order_reg;
    assign sum      = RW'(offs_reg) + count;
    assign over_end = sum > RW'(end_pg);
    assign hi       = over_end ? RW'(end_pg) : sum;

    // Word evaluation: first clear bit and free mask
    assign zbit = first_zero(ram_rdata);
    assign cand = {ev_w_reg, zbit};
    assign lo_b = (ev_w_reg == lo_reg[RW-1:6]) ? lo_reg[5:0] : 6'd0;
    assign hi_b = (ev_w_reg == last_w_reg) ? hi_m1_reg[5:0] : 6'd63;
    assign mask = ({WB{1'b1}} << lo_b) & ({WB{1'b1}} >> (6'd63 - hi_b));

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        done_next         = 1'b0;
        iss_act_next      = iss_act_reg;
        ev_v_next         = 1'b0;
        cmd_next          = cmd_reg;
        page_next         = page_reg;
        order_next        = order_reg;
        offs_next         = offs_reg;
        lo_next           = lo_reg;
        hi_m1_next        = hi_m1_reg;
        flag_next         = flag_reg;
        last_w_next       = last_w_reg;
        iss_w_next        = iss_w_reg;
        ev_w_next         = ev_w_reg;
        found_next        = found_reg;
        status_next       = status_reg;
        page_address_next = page_address_reg;
        ram_ctl           = '0;
        ram_wdata         = ram_rdata;

        unique case (state_reg)
            bpa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd;
                    page_next  = address[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
                    order_next = order;
                    state_next = bpa_pkg::S_CHECK;
                end
            end

            bpa_pkg::S_CHECK:
            begin
                page_address_next = '0;
                if (cmd_reg == bpa_pkg::CMD_ALLOC)
                begin
                    if (order_reg != '0)
                    begin
                        status_next = bpa_pkg::ST_UNSUP;
                        done_next   = 1'b1;
                        state_next  = bpa_pkg::S_IDLE;
                    end
                    else if (end_pg == '0)
                    begin
                        status_next = bpa_pkg::ST_FULL;
                        done_next   = 1'b1;
                        state_next  = bpa_pkg::S_IDLE;
                    end
                    else
                    begin
                        hi_m1_next   = RW'(end_pg) - RW'(1);
                        last_w_next  = hi_m1_next[RW-1:6];
                        iss_w_next   = '0;
                        iss_act_next = 1'b1;
                        state_next   = bpa_pkg::S_SCAN;
                    end
                end
                else
                begin
                    if (int'(order_reg) > MAX_ORDER)
                    begin
                        status_next = bpa_pkg::ST_UNSUP;
                        done_next   = 1'b1;
                        state_next  = bpa_pkg::S_IDLE;
                    end
                    else if (diff[BASE_W] || (diff[BASE_W-1:0] >= BASE_W'(region_reg)))
                    begin
                        status_next = bpa_pkg::ST_OUTSIDE;
                        done_next   = 1'b1;
                        state_next  = bpa_pkg::S_IDLE;
                    end
                    else
                    begin
                        offs_next  = diff[bpa_pkg::REGION_W-1:0];
                        state_next = bpa_pkg::S_RANGE;
                    end
                end
            end

            bpa_pkg::S_RANGE:
            begin
                // Pages past the bitmap end are skipped and flagged
                flag_next = over_end;
                if (hi > RW'(offs_reg))
                begin
                    lo_next      = RW'(offs_reg);
                    hi_m1_next   = hi - RW'(1);
                    last_w_next  = hi_m1_next[RW-1:6];
                    iss_w_next   = lo_next[RW-1:6];
                    iss_act_next = 1'b1;
                    state_next   = bpa_pkg::S_SCAN;
                end
                else
                begin
                    status_next = bpa_pkg::ST_DOUBLE;
                    done_next   = 1'b1;
                    state_next  = bpa_pkg::S_IDLE;
                end
            end

            bpa_pkg::S_SCAN:
            begin
                // Evaluate the word read last cycle, write back any update
                if (ev_v_reg)
                begin
                    if (cmd_reg == bpa_pkg::CMD_ALLOC)
                    begin
                        if (ram_rdata != {WB{1'b1}})
                        begin
                            if (cand >= RW'(end_pg))
                            begin
                                status_next = bpa_pkg::ST_FULL;
                                done_next   = 1'b1;
                                state_next  = bpa_pkg::S_IDLE;
                            end
                            else
                            begin
                                ram_ctl.wr_en = 1'b1;
                                ram_wdata     = ram_rdata | (WB'(1) << zbit);
                                found_next    = cand;
                                state_next    = bpa_pkg::S_ADDR;
                            end
                        end
                    end
                    else
                    begin
                        ram_ctl.wr_en = 1'b1;
                        ram_wdata     = ram_rdata & ~mask;
                        if ((ram_rdata & mask) != mask)
                            flag_next = 1'b1;
                        if (ev_w_reg == last_w_reg)
                        begin
                            status_next = (flag_next) ? bpa_pkg::ST_DOUBLE : bpa_pkg::ST_OK;
                            done_next   = 1'b1;
                            state_next  = bpa_pkg::S_IDLE;
                        end
                    end
                end
                else if (!iss_act_reg)
                begin
                    // Every word in range was full
                    status_next = bpa_pkg::ST_FULL;
                    done_next   = 1'b1;
                    state_next  = bpa_pkg::S_IDLE;
                end

                // Issue the next word read
                if (iss_act_reg && (state_next == bpa_pkg::S_SCAN))
                begin
                    ram_ctl.rd_en = 1'b1;
                    ev_v_next     = 1'b1;
                    ev_w_next     = iss_w_reg;
                    iss_w_next    = iss_w_reg + WN_W'(1);
                    iss_act_next  = (iss_w_reg != last_w_reg);
                end
                else if (state_next != bpa_pkg::S_SCAN)
                begin
                    iss_act_next = 1'b0;
                end
            end

            bpa_pkg::S_ADDR:
            begin
                page_address_next = {pool_base_reg + BASE_W'(found_reg),
                                     {bpa_pkg::PAGE_SHIFT{1'b0}}};
                status_next       = bpa_pkg::ST_OK;
                done_next         = 1'b1;
                state_next        = bpa_pkg::S_IDLE;
            end

            default:
            begin
                state_next = bpa_pkg::S_IDLE;
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpa_pkg::S_IDLE;
            done_reg      <= 1'b0;
            iss_act_reg   <= 1'b0;
            ev_v_reg      <= 1'b0;
            pool_base_reg <= '0;
            region_reg    <= bpa_pkg::REGION_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            iss_act_reg <= iss_act_next;
            ev_v_reg    <= ev_v_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    bpa_pkg::CFG_POOL_BASE:    pool_base_reg <= cfg_data;
                    bpa_pkg::CFG_REGION_PAGES: region_reg <= cfg_data[bpa_pkg::REGION_W-1:0];
                    default:                   pool_base_reg <= pool_base_reg;
                endcase
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        page_reg         <= page_next;
        order_reg        <= order_next;
        offs_reg         <= offs_next;
        lo_reg           <= lo_next;
        hi_m1_reg        <= hi_m1_next;
        flag_reg         <= flag_next;
        last_w_reg       <= last_w_next;
        iss_w_reg        <= iss_w_next;
        ev_w_reg         <= ev_w_next;
        found_reg        <= found_next;
        status_reg       <= status_next;
        page_address_reg <= page_address_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign page_address = page_address_reg;

`ifndef SYNTH
    // No bitmap write may slip in while the clearing sweep owns the memory
    a_no_wr_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !ram_ctl.wr_en)
        else $error("bitmap write during clearing pass");

    // Only a successful allocate carries an address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != bpa_pkg::ST_OK) |-> page_address == '0)
        else $error("address on a failed result");

    // A result only follows work in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg != bpa_pkg::S_IDLE))
        else $error("result without a request");

    // The word under evaluation never runs past the last word of the range
    a_ev_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bpa_pkg::S_SCAN) && ev_v_reg |-> ev_w_reg <= last_w_reg)
        else $error("scan ran past its range");
`endif

endmodule
